FILE: rtl/ljmic_pkg.sv
// Package for the Lennard-Jones minimum-image energy accumulator.
// Holds payload structs, widths, config register indexes and the back-end sequencer state enum.
// No dependencies.
package ljmic_pkg;

	localparam int unsigned CoordFracBitsDefault = 16;
	localparam int unsigned BoxW = 31;
	localparam int unsigned CfgIdxW = 2;

	localparam logic [CfgIdxW-1:0] RegBoxX = 2'd0;
	localparam logic [CfgIdxW-1:0] RegBoxY = 2'd1;
	localparam logic [CfgIdxW-1:0] RegBoxZ = 2'd2;

	typedef struct packed {
		logic signed [31:0] own_x;
		logic signed [31:0] own_y;
		logic signed [31:0] own_z;
		logic [23:0]        own_sigma;
		logic [23:0]        own_epsilon;
		logic signed [31:0] partner_x;
		logic signed [31:0] partner_y;
		logic signed [31:0] partner_z;
		logic [23:0]        partner_sigma;
		logic [23:0]        partner_epsilon;
		logic               last_pair;
	} pair_in_t;

	typedef struct packed {
		logic signed [63:0] total_energy;
		logic               saturated;
	} energy_out_t;

	// Classified pair handed from the front to the back end.
	typedef struct packed {
		logic [63:0] r2;
		logic [47:0] sig2;
		logic [47:0] epsprod;
		logic        last_pair;
	} pair_job_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQRT,
		ST_DIV,
		ST_SQ,
		ST_CUBE,
		ST_SIX,
		ST_MAG,
		ST_TERM,
		ST_ACC,
		ST_EMIT
	} back_state_t;

endpackage

FILE: rtl/lennard_jones_energy_mic_accumulator.sv
// Lennard-Jones 12-6 energy accumulator with minimum-image box folding.
// The back end works on one pair at a time, built from the bit-serial sqrt (24 steps),
// the 64-step Q32 divider and four four-pass partial-product multiplies; a clamped
// ratio skips the divide steps. Up to four pairs wait ahead of it in front end and queue.
// Reset (arst_n low, asynchronous) clears box lengths, the sum, flag and all valids.
module lennard_jones_energy_mic_accumulator #(
	parameter int unsigned COORD_FRAC_BITS = ljmic_pkg::CoordFracBitsDefault
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ljmic_pkg::pair_in_t           in_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	output ljmic_pkg::energy_out_t        out_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	input  logic [ljmic_pkg::CfgIdxW-1:0] cfg_index,
	input  logic [ljmic_pkg::BoxW-1:0]    cfg_data,
	input  logic                          cfg_valid,
	output logic                          cfg_ready
);
	import ljmic_pkg::*;

	logic [BoxW-1:0] box_x_q, box_y_q, box_z_q;
	pair_job_t fj, qj;
	logic      fj_valid, fj_ready, qj_valid, qj_ready;

	// Take configuration writes at any time; unknown indexes drop.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_x_q <= '0;
			box_y_q <= '0;
			box_z_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				RegBoxX: box_x_q <= cfg_data;
				RegBoxY: box_y_q <= cfg_data;
				RegBoxZ: box_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	ljmic_front u_front (
		.clk, .arst_n,
		.pair_in(in_data), .in_valid, .in_ready,
		.box_x(box_x_q), .box_y(box_y_q), .box_z(box_z_q),
		.job(fj), .job_valid(fj_valid), .job_ready(fj_ready)
	);

	ljmic_queue u_queue (
		.clk, .arst_n,
		.wr_data(fj), .wr_valid(fj_valid), .wr_ready(fj_ready),
		.rd_data(qj), .rd_valid(qj_valid), .rd_ready(qj_ready)
	);

	ljmic_back #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_back (
		.clk, .arst_n,
		.job(qj), .job_valid(qj_valid), .job_ready(qj_ready),
		.result(out_data), .out_valid, .out_ready
	);

endmodule

FILE: rtl/ljmic_front.sv
// Front end: folds coordinate differences into the box and forms r2, sig2 and eps product.
// Depends on ljmic_pkg. Two registered stages with a valid/ready handshake.
module ljmic_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  ljmic_pkg::pair_in_t         pair_in,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [ljmic_pkg::BoxW-1:0]  box_x,
	input  logic [ljmic_pkg::BoxW-1:0]  box_y,
	input  logic [ljmic_pkg::BoxW-1:0]  box_z,
	output ljmic_pkg::pair_job_t        job,
	output logic                        job_valid,
	input  logic                        job_ready
);
	import ljmic_pkg::*;

	logic        v_s1;
	logic [30:0] m_s1 [3];
	logic [24:0] sigsum_s1;
	logic [47:0] epsprod_s1;
	logic        last_s1;
	logic        adv_s1;
	logic [30:0] m_d  [3];

	function automatic logic [30:0] fold(input logic signed [31:0] a,
		input logic signed [31:0] b, input logic [30:0] box);
		logic signed [33:0] d;
		logic signed [34:0] d2;
		logic signed [34:0] bx;
		logic [33:0] m;
		d  = 34'(a) - 34'(b);
		d2 = 35'(d) <<< 1;
		bx = 35'(signed'({1'b0, box}));
		if (d2 > bx)
			d = d - 34'(signed'({1'b0, box}));
		else if (d2 < -bx)
			d = d + 34'(signed'({1'b0, box}));
		m = d[33] ? 34'(-d) : 34'(d);
		fold = (m > 34'h7FFFFFFF) ? 31'h7FFFFFFF : m[30:0];
	endfunction

	assign m_d[0] = fold(pair_in.own_x, pair_in.partner_x, box_x);
	assign m_d[1] = fold(pair_in.own_y, pair_in.partner_y, box_y);
	assign m_d[2] = fold(pair_in.own_z, pair_in.partner_z, box_z);

	// Stage 2 output register doubles as the skid toward the queue.
	assign adv_s1   = v_s1 && (!job_valid || job_ready);
	assign in_ready = !v_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			m_s1       <= m_d;
			sigsum_s1  <= 25'(pair_in.own_sigma) + 25'(pair_in.partner_sigma);
			epsprod_s1 <= pair_in.own_epsilon * pair_in.partner_epsilon;
			last_s1    <= pair_in.last_pair;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid <= 1'b0;
		end else if (!job_valid || job_ready) begin
			job_valid <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			job.r2 <= 64'(m_s1[0] * m_s1[0]) + 64'(m_s1[1] * m_s1[1])
				+ 64'(m_s1[2] * m_s1[2]);
			job.sig2      <= sigsum_s1[24:1] * sigsum_s1[24:1];
			job.epsprod   <= epsprod_s1;
			job.last_pair <= last_s1;
		end
	end

endmodule

FILE: rtl/ljmic_queue.sv
// Short queue between front and back end.
// Depends on ljmic_pkg. Two-entry register FIFO.
module ljmic_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ljmic_pkg::pair_job_t  wr_data,
	input  logic                  wr_valid,
	output logic                  wr_ready,
	output ljmic_pkg::pair_job_t  rd_data,
	output logic                  rd_valid,
	input  logic                  rd_ready
);
	import ljmic_pkg::*;

	pair_job_t mem_q [2];
	logic      wp_q, rp_q;
	logic [1:0] cnt_q;
	logic      wr_en, rd_en;

	assign wr_ready = (cnt_q != 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign wr_en    = wr_valid && wr_ready;
	assign rd_en    = rd_valid && rd_ready;
	assign rd_data  = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr_en) wp_q <= ~wp_q;
			if (rd_en) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(wr_en) - 2'(rd_en);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wp_q] <= wr_data;
		end
	end

endmodule

FILE: rtl/ljmic_back.sv
// Back end: sqrt of eps product, Q32 ratio divide, power chain, term and saturating sum.
// Depends on ljmic_pkg. Sequencer over a bit-serial sqrt/divide and 32x32 partial products.
module ljmic_back #(
	parameter int unsigned COORD_FRAC_BITS = ljmic_pkg::CoordFracBitsDefault
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  ljmic_pkg::pair_job_t    job,
	input  logic                    job_valid,
	output logic                    job_ready,
	output ljmic_pkg::energy_out_t  result,
	output logic                    out_valid,
	input  logic                    out_ready
);
	import ljmic_pkg::*;

	localparam int unsigned IterW = 7;

	back_state_t st_q, st_d;
	logic [IterW-1:0] it_q;
	pair_job_t   job_q;
	logic [63:0] q_q, q3_q, q6_q;
	logic [24:0] rt_q;
	logic [49:0] rem_s_q;
	logic [47:0] rad_q;
	logic [64:0] rem_q;
	logic [63:0] lo_q;
	logic        csat_q;
	logic        neg_q;
	logic signed [63:0] term_q;
	logic signed [63:0] sum_q;
	logic        satf_q;
	logic        ovf_q;
	// Multiplier operands, one 32x32 partial product a cycle.
	logic [63:0] ma_q, mb_q;
	logic [127:0] acc_q;
	logic [1:0]  pp_q;
	logic [63:0] pp;
	logic [31:0] pa, pb;
	logic        mul_done;

	assign job_ready = (st_q == ST_IDLE);

	always_comb begin
		pa = pp_q[0] ? ma_q[63:32] : ma_q[31:0];
		pb = pp_q[1] ? mb_q[63:32] : mb_q[31:0];
		pp = pa * pb;
	end
	assign mul_done = (pp_q == 2'd3);

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE: if (job_valid) st_d = ST_SQRT;
			ST_SQRT: if (it_q == IterW'(23)) st_d = ST_DIV;
			ST_DIV:  if (it_q == IterW'(64) || it_q == '1) st_d = ST_SQ;
			ST_SQ:   if (mul_done) st_d = ST_CUBE;
			ST_CUBE: if (mul_done) st_d = ST_SIX;
			ST_SIX:  if (mul_done) st_d = ST_MAG;
			ST_MAG:  st_d = ST_TERM;
			ST_TERM: if (mul_done) st_d = ST_ACC;
			ST_ACC:  st_d = job_q.last_pair ? ST_EMIT : ST_IDLE;
			ST_EMIT: if (!out_valid || out_ready) st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_IDLE;
			sum_q     <= '0;
			satf_q    <= 1'b0;
			out_valid <= 1'b0;
			result    <= '0;
		end else begin
			st_q <= st_d;
			if (out_valid && out_ready) out_valid <= 1'b0;
			if (st_q == ST_ACC) begin
				logic signed [64:0] s;
				s = 65'(sum_q) + 65'(term_q);
				if (s[64] != s[63]) begin
					sum_q  <= s[64] ? 64'sh8000000000000000 : 64'sh7FFFFFFFFFFFFFFF;
					satf_q <= 1'b1;
				end else begin
					sum_q <= s[63:0];
				end
				if (ovf_q) satf_q <= 1'b1;
			end
			if (st_q == ST_EMIT && (!out_valid || out_ready)) begin
				out_valid             <= 1'b1;
				result.total_energy <= sum_q;
				result.saturated    <= satf_q;
				sum_q                 <= '0;
				satf_q                <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			ST_IDLE: begin
				job_q   <= job;
				it_q    <= '0;
				rt_q    <= '0;
				rem_s_q <= '0;
				rad_q   <= job.epsprod;
				csat_q  <= 1'b0;
				ovf_q   <= 1'b0;
			end
			ST_SQRT: begin
				// One result bit a step, radicand consumed two bits at a time.
				logic [49:0] r;
				logic [49:0] t;
				r = {rem_s_q[47:0], rad_q[47:46]};
				t = {23'b0, rt_q, 2'b01};
				if (r >= t) begin
					rem_s_q <= r - t;
					rt_q    <= {rt_q[23:0], 1'b1};
				end else begin
					rem_s_q <= r;
					rt_q    <= {rt_q[23:0], 1'b0};
				end
				rad_q <= {rad_q[45:0], 2'b00};
				if (it_q == IterW'(23)) begin
					it_q  <= '0;
					rem_q <= '0;
					lo_q  <= {job_q.sig2[31:0], 32'b0};
					q_q   <= '0;
					if (job_q.r2 == '0) begin
						it_q   <= '1;
						csat_q <= (job_q.sig2 != '0);
						q_q    <= (job_q.sig2 != '0) ? '1 : '0;
					end else if (64'(job_q.sig2[47:32]) >= job_q.r2) begin
						it_q   <= '1;
						csat_q <= 1'b1;
						q_q    <= '1;
					end else begin
						rem_q <= 65'(job_q.sig2[47:32]);
					end
				end else begin
					it_q <= it_q + 1'b1;
				end
			end
			ST_DIV: begin
				if (it_q != '1 && it_q != IterW'(64)) begin
					logic [64:0] r;
					r = {rem_q[63:0], lo_q[63]};
					lo_q <= {lo_q[62:0], 1'b0};
					if (r >= 65'(job_q.r2)) begin
						rem_q <= r - 65'(job_q.r2);
						q_q   <= {q_q[62:0], 1'b1};
					end else begin
						rem_q <= r;
						q_q   <= {q_q[62:0], 1'b0};
					end
					it_q <= it_q + 1'b1;
				end
				// Quotient is complete here; load it as both multiplier operands.
				if (st_d == ST_SQ) begin
					ma_q  <= q_q;
					mb_q  <= q_q;
					pp_q  <= '0;
					acc_q <= '0;
				end
			end
			default: ;
		endcase
		if (st_q == ST_SQ || st_q == ST_CUBE || st_q == ST_SIX || st_q == ST_TERM) begin
			logic [127:0] sh;
			sh = 128'(pp) << (32 * (int'(pp_q[0]) + int'(pp_q[1])));
			acc_q <= acc_q + sh;
			pp_q  <= pp_q + 1'b1;
			if (mul_done) begin
				logic [127:0] f;
				f = acc_q + sh;
				pp_q  <= '0;
				acc_q <= '0;
				unique case (st_q)
					ST_SQ: begin
						if (f[127:96] != '0) begin
							csat_q <= 1'b1; ma_q <= '1;
						end else begin
							ma_q <= f[95:32];
						end
						mb_q <= q_q;
					end
					ST_CUBE: begin
						if (f[127:96] != '0) begin
							csat_q <= 1'b1; q3_q <= '1; ma_q <= '1; mb_q <= '1;
						end else begin
							q3_q <= f[95:32]; ma_q <= f[95:32]; mb_q <= f[95:32];
						end
					end
					ST_SIX: begin
						if (f[127:96] != '0) begin
							csat_q <= 1'b1; q6_q <= '1;
						end else begin
							q6_q <= f[95:32];
						end
					end
					default: begin
						// Term: 4*epsc*mag >> F.
						logic [127:0] r;
						r = f >> COORD_FRAC_BITS;
						if (rt_q == '0) begin
							term_q <= '0;
						end else if (csat_q) begin
							term_q <= 64'sh7FFFFFFFFFFFFFFF;
							ovf_q  <= 1'b1;
						end else if (r[127:63] != '0) begin
							term_q <= neg_q ? 64'sh8000000000000000 : 64'sh7FFFFFFFFFFFFFFF;
							ovf_q  <= 1'b1;
						end else begin
							term_q <= neg_q ? -$signed(r[63:0]) : $signed(r[63:0]);
						end
					end
				endcase
			end
		end
		if (st_q == ST_MAG) begin
			neg_q <= (q6_q < q3_q);
			ma_q  <= {37'b0, rt_q, 2'b00};
			mb_q  <= (q6_q < q3_q) ? q3_q - q6_q : q6_q - q3_q;
			pp_q  <= '0;
			acc_q <= '0;
		end
	end

endmodule

FILE: bench/lennard_jones_energy_mic_accumulator_test.sv
// Testbench for lennard_jones_energy_mic_accumulator: drives atom pairs and box writes,
// predicts each set's Lennard-Jones energy sum and compares every result item.
// Depends on ljmic_pkg and the accumulator RTL only.
module lennard_jones_energy_mic_accumulator_test;
	import ljmic_pkg::*;

	localparam int unsigned FracBits = CoordFracBitsDefault;
	localparam logic [63:0] SatMax = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] SatMin = 64'h8000_0000_0000_0000;
	localparam logic [63:0] AllOnes = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [30:0] BoxMax = 31'h7FFF_FFFF;
	// after the last result a pair with no result may still be in the back end
	localparam int SettleCycles = 600;

	logic clk;
	logic arst_n;
	pair_in_t in_data;
	logic in_valid;
	logic in_ready;
	energy_out_t out_data;
	logic out_valid;
	logic out_ready;
	logic [CfgIdxW-1:0] cfg_index;
	logic [BoxW-1:0] cfg_data;
	logic cfg_valid;
	logic cfg_ready;

	// predictor state: box lengths, running sum and saturation flag
	logic [30:0] box_len [3];
	logic signed [63:0] energy_acc;
	logic energy_sat;

	energy_out_t energy_expected [$];
	int mismatches;
	int pairs_sent;
	int energies_checked;
	bit steady;
	int hold_requests;
	int hold_served;
	int hold_left;

	lennard_jones_energy_mic_accumulator DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_data(in_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.out_data(out_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Hard stop well beyond the slowest legal run.
	initial begin
		#30_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	function automatic logic [23:0] floor_sqrt48(input logic [47:0] v);
		logic [23:0] res;
		logic [23:0] trial;
		res = '0;
		for (int i = 23; i >= 0; i--) begin
			trial = res | (24'd1 << i);
			if (48'(trial) * 48'(trial) <= v)
				res = trial;
		end
		return res;
	endfunction

	// Q32.32 multiply with clamp; any clamp marks the power chain saturated.
	function automatic logic [63:0] mul_q32(input logic [63:0] a, input logic [63:0] b,
			inout logic sat);
		logic [127:0] p;
		p = 128'(a) * 128'(b);
		if (p[127:96] != '0) begin
			sat = 1'b1;
			return AllOnes;
		end
		return p[95:32];
	endfunction

	// Fold one pair into the running sum; returns 1 with the energy when the set ends.
	function automatic bit lj_pair_energy(input pair_in_t p, output energy_out_t res);
		logic signed [31:0] own_c [3];
		logic signed [31:0] par_c [3];
		longint d;
		longint bx;
		longint m;
		logic [63:0] r2;
		logic [24:0] sig;
		logic [47:0] sig2;
		logic [23:0] epsc;
		logic [63:0] q;
		logic [63:0] q3;
		logic [63:0] q6;
		logic [63:0] mag;
		logic [127:0] wide;
		logic signed [63:0] term;
		logic signed [64:0] total;
		logic chain_sat;
		logic neg;
		own_c = '{p.own_x, p.own_y, p.own_z};
		par_c = '{p.partner_x, p.partner_y, p.partner_z};
		r2 = '0;
		chain_sat = 1'b0;
		term = '0;
		for (int k = 0; k < 3; k++) begin
			d = longint'(own_c[k]) - longint'(par_c[k]);
			bx = longint'({33'd0, box_len[k]});
			if (2 * d > bx)
				d -= bx;
			else if (2 * d < -bx)
				d += bx;
			m = (d < 0) ? -d : d;
			if (m > 64'h7FFF_FFFF)
				m = 64'h7FFF_FFFF;
			r2 += 64'(m * m);
		end
		sig = (25'(p.own_sigma) + 25'(p.partner_sigma)) >> 1;
		sig2 = 48'(sig) * 48'(sig);
		epsc = floor_sqrt48(48'(p.own_epsilon) * 48'(p.partner_epsilon));
		if (r2 == '0) begin
			chain_sat = (sig2 != '0);
			q = chain_sat ? AllOnes : '0;
		end else begin
			wide = (128'(sig2) << 32) / 128'(r2);
			if (wide[127:64] != '0) begin
				chain_sat = 1'b1;
				q = AllOnes;
			end else begin
				q = wide[63:0];
			end
		end
		q3 = mul_q32(mul_q32(q, q, chain_sat), q, chain_sat);
		q6 = mul_q32(q3, q3, chain_sat);
		if (epsc == '0) begin
			term = '0;
		end else if (chain_sat) begin
			term = SatMax;
			energy_sat = 1'b1;
		end else begin
			neg = q6 < q3;
			mag = neg ? q3 - q6 : q6 - q3;
			wide = 128'({epsc, 2'b00}) * 128'(mag);
			if (wide[127:64+FracBits] != '0 || wide[63+FracBits]) begin
				energy_sat = 1'b1;
				term = neg ? SatMin : SatMax;
			end else begin
				term = neg ? -$signed(wide[63+FracBits:FracBits])
					: $signed(wide[63+FracBits:FracBits]);
			end
		end
		total = {energy_acc[63], energy_acc} + {term[63], term};
		if (total[64] != total[63]) begin
			energy_sat = 1'b1;
			energy_acc = total[64] ? SatMin : SatMax;
		end else begin
			energy_acc = total[63:0];
		end
		res.total_energy = energy_acc;
		res.saturated = energy_sat;
		if (p.last_pair) begin
			energy_acc = '0;
			energy_sat = 1'b0;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// Offer one pair, idling at random first unless steady; predict on acceptance.
	task automatic send_pair(input pair_in_t p);
		energy_out_t res;
		@(negedge clk);
		while (!steady && $urandom_range(99) < 21) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= p;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		pairs_sent++;
		if (lj_pair_energy(p, res))
			energy_expected.push_back(res);
	endtask

	// Drop valid and hold off until every expected energy has come back.
	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (energy_expected.size() != 0)
			@(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic write_box(input logic [CfgIdxW-1:0] idx, input logic [30:0] len);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= len;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		box_len[idx] = len;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_box(input logic [30:0] bx, input logic [30:0] by, input logic [30:0] bz);
		drain_results();
		write_box(RegBoxX, bx);
		write_box(RegBoxY, by);
		write_box(RegBoxZ, bz);
	endtask

	function automatic logic signed [31:0] rand_coord();
		return $signed(32'($urandom_range(4_194_304))) - 32'sd2_097_152;
	endfunction

	// Mostly physical pairs (close neighbours, sane sigma and epsilon, some near the
	// periodic boundary), the rest raw noise over every bit.
	function automatic pair_in_t make_pair(input bit last);
		pair_in_t p;
		int kind;
		kind = $urandom_range(99);
		if (kind < 25) begin
			p = pair_in_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom, $urandom, 1'b0});
		end else begin
			p.own_x = rand_coord();
			p.own_y = rand_coord();
			p.own_z = rand_coord();
			p.partner_x = p.own_x + $signed(32'($urandom_range(1_048_576))) - 32'sd524_288;
			p.partner_y = p.own_y + $signed(32'($urandom_range(1_048_576))) - 32'sd524_288;
			p.partner_z = p.own_z + $signed(32'($urandom_range(1_048_576))) - 32'sd524_288;
			if (kind < 40) begin
				// push the partner roughly one box length away to exercise folding
				p.partner_x = p.partner_x + $signed({1'b0, box_len[0]});
				p.partner_y = p.partner_y - $signed({1'b0, box_len[1]});
			end
			if (kind < 45)
				p.partner_z = p.own_z;
			p.own_sigma = 24'($urandom_range(262_144, 163_840));
			p.partner_sigma = 24'($urandom_range(262_144, 163_840));
			p.own_epsilon = 24'($urandom_range(65_536));
			p.partner_epsilon = 24'($urandom_range(65_536));
		end
		p.last_pair = last;
		return p;
	endfunction

	// Sets of one to eight pairs; the phase always closes its set.
	task automatic test_random_sets(input int count);
		int left;
		left = 0;
		for (int i = 0; i < count; i++) begin
			if (left == 0)
				left = $urandom_range(8, 1);
			left--;
			send_pair(make_pair(left == 0 || i == count - 1));
		end
	endtask

	task automatic test_directed();
		pair_in_t p;
		p = '0;
		// coincident atoms with zero sigma: ratio is zero, term zero
		p.last_pair = 1'b1;
		send_pair(p);
		// coincident atoms with sigma: ratio clamps, term saturates
		p.own_sigma = 24'h03_6666;
		p.partner_sigma = 24'h03_6666;
		p.own_epsilon = 24'h00_4000;
		p.partner_epsilon = 24'h00_4000;
		send_pair(p);
		// same again but zero combined epsilon: no term, no flag
		p.partner_epsilon = '0;
		send_pair(p);
		// every field at its extremes
		p = '1;
		send_pair(p);
		p = '0;
		p.own_x = 32'sh7FFF_FFFF;
		p.partner_x = 32'sh8000_0000;
		p.own_y = 32'sh8000_0000;
		p.partner_y = 32'sh7FFF_FFFF;
		p.own_z = 32'sh7FFF_FFFF;
		p.own_sigma = 24'hFF_FFFF;
		p.partner_sigma = 24'hFF_FFFF;
		p.own_epsilon = 24'hFF_FFFF;
		p.partner_epsilon = 24'hFF_FFFF;
		p.last_pair = 1'b1;
		send_pair(p);
		// near contact: large repulsive term, and three of them push the sum to its clamp
		p = '0;
		p.own_x = 32'sh0000_8000;
		p.own_sigma = 24'h04_0000;
		p.partner_sigma = 24'h04_0000;
		p.own_epsilon = 24'hFF_FFFF;
		p.partner_epsilon = 24'hFF_FFFF;
		repeat (3)
			send_pair(p);
		p.last_pair = 1'b1;
		send_pair(p);
		// attractive tail: distance beyond sigma gives a negative term
		p.own_x = 32'sh0004_0000;
		p.own_epsilon = 24'h00_8000;
		p.partner_epsilon = 24'h01_0000;
		send_pair(p);
		p.own_x = 32'sh0010_0000;
		send_pair(p);
	endtask

	// Hold the receiver off while the sender streams without gaps, then pause to drain.
	task automatic test_backpressure();
		steady = 1'b1;
		hold_requests++;
		for (int i = 0; i < 24; i++)
			send_pair(make_pair(i % 3 == 2));
		steady = 1'b0;
		drain_results();
	endtask

	// Receiver: idle at random, serve long hold-offs on request, never idle when steady unless holding off.
	always @(negedge clk) begin
		if (hold_requests != hold_served) begin
			hold_served <= hold_requests;
			hold_left <= 900;
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else if (steady) begin
			out_ready <= 1'b1;
		end else begin
			out_ready <= ($urandom_range(99) >= 21);
		end
	end

	// Compare every accepted result item with the oldest prediction.
	always @(posedge clk) begin
		energy_out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (energy_expected.size() == 0) begin
				report("unexpected result", out_data.total_energy, '0);
			end else begin
				want = energy_expected.pop_front();
				energies_checked++;
				if (out_data.total_energy !== want.total_energy)
					report("total_energy", out_data.total_energy, want.total_energy);
				if (out_data.saturated !== want.saturated)
					report("saturated", 64'(out_data.saturated), 64'(want.saturated));
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = RegBoxX;
		cfg_data = '0;
		steady = 1'b0;
		hold_requests = 0;
		hold_served = 0;
		hold_left = 0;
		mismatches = 0;
		pairs_sent = 0;
		energies_checked = 0;
		box_len = '{default: '0};
		energy_acc = '0;
		energy_sat = 1'b0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		test_directed();
		set_box(BoxMax, BoxMax, BoxMax);
		test_directed();
		test_random_sets(250);
		set_box(31'd20 << 16, 31'd24 << 16, 31'd30 << 16);
		steady = 1'b1;
		test_random_sets(150);
		steady = 1'b0;
		test_random_sets(250);
		test_backpressure();
		set_box(31'd1, '0, 31'($urandom));
		test_random_sets(300);
		set_box(31'($urandom), 31'($urandom_range(2_000_000)), 31'd16 << 16);
		test_random_sets(380);
		drain_results();

		$display("Covered %0d pairs over five box settings, %0d set energies checked,",
			pairs_sent, energies_checked);
		$display("with directed edge pairs, output hold-off and stalls on both sides.");
		if (mismatches == 0 && energy_expected.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
